// ----- sv/lc3_pkg.sv -----
// Shared types and constants for the LC-3 instruction executor.
`timescale 1ns / 1ps
package lc3_pkg;

  localparam int unsigned MemWords = 65536;
  localparam int unsigned MemAw = $clog2(MemWords);

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_SETPC = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_RUN  = 2'd0,
    ST_HALT = 2'd1,
    ST_ERR  = 2'd2,
    ST_UNUSED = 2'd3
  } stop_e;

  localparam logic [3:0] OpBr   = 4'h0;
  localparam logic [3:0] OpAdd  = 4'h1;
  localparam logic [3:0] OpLd   = 4'h2;
  localparam logic [3:0] OpSt   = 4'h3;
  localparam logic [3:0] OpJsr  = 4'h4;
  localparam logic [3:0] OpAnd  = 4'h5;
  localparam logic [3:0] OpLdr  = 4'h6;
  localparam logic [3:0] OpStr  = 4'h7;
  localparam logic [3:0] OpNot  = 4'h9;
  localparam logic [3:0] OpLdi  = 4'hA;
  localparam logic [3:0] OpSti  = 4'hB;
  localparam logic [3:0] OpJmp  = 4'hC;
  localparam logic [3:0] OpLea  = 4'hE;
  localparam logic [3:0] OpTrap = 4'hF;

  localparam logic [7:0] TrapGetc = 8'h20;
  localparam logic [7:0] TrapOut  = 8'h21;
  localparam logic [7:0] TrapPuts = 8'h22;
  localparam logic [7:0] TrapIn   = 8'h23;
  localparam logic [7:0] TrapHalt = 8'h25;

  // Memory address source selected by the controller.
  typedef enum logic [1:0] {
    AS_PC   = 2'd0,
    AS_EA   = 2'd1,
    AS_MDR  = 2'd2,
    AS_CUR  = 2'd3
  } asel_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic  load_in;
    logic  mem_rd;
    logic  mem_wr;
    logic  wr_host;
    asel_e asel;
    logic  load_ir;
    logic  exec;
    logic  ld_finish;
    logic  puts_step;
    logic  result;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    cmd_e       cmd;
    logic       stopped;
    logic       str_active;
    logic [3:0] op;
  } dp_stat_t;

endpackage

// ----- sv/lc3_datapath.sv -----
// LC-3 datapath: memory, register file, program counter and result registers.
`timescale 1ns / 1ps
module lc3_datapath import lc3_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_stat_t    stat_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] address_i,
  input  logic [15:0] data_i,
  input  logic [7:0]  in_char_i,
  output logic [1:0]  status_o,
  output logic        char_valid_o,
  output logic [7:0]  char_out_o,
  output logic        input_used_o,
  output logic [15:0] pc_now_o
);

  logic [15:0] mem [MemWords];
  logic [15:0] mdr_q;
  logic [15:0] gpr_q [8];
  logic [2:0]  nzp_q;
  logic [15:0] pc_q, cur_q, ir_q, ea_q;
  logic        str_q;
  stop_e       stop_q;
  logic [1:0]  cmd_q;
  logic [15:0] adr_q, dat_q;
  logic [7:0]  ch_q;
  logic [1:0]  status_q;
  logic        cv_q, cv_d, used_q, used_d;
  logic [7:0]  co_q, co_d;

  logic [MemAw-1:0] maddr;
  logic [15:0] wdata;
  logic [2:0]  dr, sr1, sr2;
  logic [15:0] s5, s6, s9, s11, op2, alu;

  assign dr  = ir_q[11:9];
  assign sr1 = ir_q[8:6];
  assign sr2 = ir_q[2:0];
  assign s5  = {{11{ir_q[4]}}, ir_q[4:0]};
  assign s6  = {{10{ir_q[5]}}, ir_q[5:0]};
  assign s9  = {{7{ir_q[8]}}, ir_q[8:0]};
  assign s11 = {{5{ir_q[10]}}, ir_q[10:0]};
  assign op2 = ir_q[5] ? s5 : gpr_q[sr2];
  assign alu = (ir_q[15:12] == OpAdd) ? gpr_q[sr1] + op2 : gpr_q[sr1] & op2;

  always_comb begin
    case (cmd_i.asel)
      AS_PC:   maddr = pc_q;
      AS_EA:   maddr = ea_q;
      AS_MDR:  maddr = mdr_q;
      AS_CUR:  maddr = cur_q;
      default: maddr = pc_q;
    endcase
  end
  assign wdata = cmd_i.wr_host ? dat_q : gpr_q[dr];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem[cmd_i.wr_host ? adr_q : maddr] <= wdata;
    end
    if (cmd_i.mem_rd) begin
      mdr_q <= mem[maddr];
    end
  end

  function automatic logic [2:0] flags(input logic [15:0] v);
    if (v == 16'h0) return 3'b010;
    else if (v[15]) return 3'b100;
    else return 3'b001;
  endfunction

  always_comb begin
    cv_d = 1'b0;
    co_d = 8'h00;
    used_d = 1'b0;
    if (cmd_i.exec && ir_q[15:12] == OpTrap) begin
      case (ir_q[7:0])
        TrapGetc: used_d = 1'b1;
        TrapOut: begin
          cv_d = 1'b1;
          co_d = gpr_q[0][7:0];
        end
        TrapIn: begin
          cv_d = 1'b1;
          co_d = ch_q;
          used_d = 1'b1;
        end
        default: ;
      endcase
    end else if (cmd_i.puts_step && mdr_q != 16'h0) begin
      cv_d = 1'b1;
      co_d = mdr_q[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) gpr_q[i] <= 16'h0;
      nzp_q <= 3'b000;
      pc_q <= 16'h0;
      cur_q <= 16'h0;
      str_q <= 1'b0;
      stop_q <= ST_RUN;
      status_q <= 2'd0;
      cv_q <= 1'b0;
      co_q <= 8'h00;
      used_q <= 1'b0;
      cmd_q <= 2'd0;
    end else begin
      if (cmd_i.load_in) begin
        cmd_q <= command_i;
        adr_q <= address_i;
        dat_q <= data_i;
        ch_q  <= in_char_i;
        cv_q  <= 1'b0;
        co_q  <= 8'h00;
        used_q <= 1'b0;
      end
      if (cmd_i.load_ir) begin
        ir_q <= mdr_q;
        pc_q <= pc_q + 16'd1;
      end
      if (cmd_i.exec) begin
        cv_q <= cv_d;
        co_q <= co_d;
        used_q <= used_d;
        case (ir_q[15:12])
          OpBr: if ((dr & nzp_q) != 3'b000) pc_q <= pc_q + s9;
          OpAdd, OpAnd: begin
            gpr_q[dr] <= alu;
            nzp_q <= flags(alu);
          end
          OpLd, OpSt, OpLdi, OpSti: ea_q <= pc_q + s9;
          OpLdr, OpStr: ea_q <= gpr_q[sr1] + s6;
          OpJsr: begin
            gpr_q[7] <= pc_q;
            pc_q <= ir_q[11] ? pc_q + s11 : gpr_q[sr1];
          end
          OpNot: begin
            gpr_q[dr] <= ~gpr_q[sr1];
            nzp_q <= flags(~gpr_q[sr1]);
          end
          OpJmp: pc_q <= gpr_q[sr1];
          OpLea: begin
            gpr_q[dr] <= pc_q + s9;
            nzp_q <= flags(pc_q + s9);
          end
          OpTrap: begin
            case (ir_q[7:0])
              TrapGetc, TrapIn: gpr_q[0] <= {8'h00, ch_q};
              TrapPuts: begin
                cur_q <= gpr_q[0];
                str_q <= 1'b1;
              end
              TrapHalt: stop_q <= ST_HALT;
              default: ;
            endcase
          end
          default: stop_q <= ST_ERR;
        endcase
      end
      if (cmd_i.ld_finish) begin
        gpr_q[dr] <= mdr_q;
        nzp_q <= flags(mdr_q);
      end
      if (cmd_i.puts_step) begin
        cv_q <= cv_d;
        co_q <= co_d;
        if (mdr_q == 16'h0) str_q <= 1'b0;
        else cur_q <= cur_q + 16'd1;
      end
      if (cmd_i.result && cmd_q == CMD_SETPC) begin
        pc_q <= dat_q;
        stop_q <= ST_RUN;
        str_q <= 1'b0;
      end
      if (cmd_i.result) begin
        status_q <= (cmd_q == CMD_SETPC) ? 2'(ST_RUN) : 2'(stop_q);
      end
    end
  end

  assign stat_o = '{cmd: cmd_e'(cmd_q), stopped: (stop_q != ST_RUN),
                    str_active: str_q, op: ir_q[15:12]};

  assign status_o     = status_q;
  assign char_valid_o = cv_q;
  assign char_out_o   = co_q;
  assign input_used_o = used_q;
  assign pc_now_o     = pc_q;

endmodule

// ----- sv/lc3_ctrl.sv -----
// LC-3 controller state machine sequencing memory accesses per transaction.
`timescale 1ns / 1ps
module lc3_ctrl import lc3_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  output logic     done_o,
  output dp_cmd_t  cmd_o,
  input  dp_stat_t stat_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_FETCH, S_DEC, S_EXEC, S_IND, S_DATA, S_LDW, S_PUTS, S_DONE
  } state_e;

  state_e state_q;
  logic   busy_q, done_q;
  logic   is_ld, is_st, is_ind;

  assign is_ld  = stat_i.op == OpLd || stat_i.op == OpLdr || stat_i.op == OpLdi;
  assign is_st  = stat_i.op == OpSt || stat_i.op == OpStr || stat_i.op == OpSti;
  assign is_ind = stat_i.op == OpLdi || stat_i.op == OpSti;

  always_comb begin
    cmd_o = '0;
    cmd_o.asel = AS_PC;
    cmd_o.load_in = start_i && !busy_q;
    case (state_q)
      S_DISP: begin
        if (stat_i.cmd == CMD_WRITE) begin
          cmd_o.mem_wr = 1'b1;
          cmd_o.wr_host = 1'b1;
        end else if (stat_i.cmd == CMD_STEP && !stat_i.stopped) begin
          cmd_o.mem_rd = 1'b1;
          cmd_o.asel = stat_i.str_active ? AS_CUR : AS_PC;
        end
      end
      S_FETCH: cmd_o.load_ir = 1'b1;
      S_EXEC:  cmd_o.exec = 1'b1;
      S_IND: begin
        cmd_o.mem_rd = 1'b1;
        cmd_o.asel = AS_EA;
      end
      S_DATA: begin
        cmd_o.asel = is_ind ? AS_MDR : AS_EA;
        cmd_o.mem_rd = is_ld;
        cmd_o.mem_wr = is_st;
      end
      S_LDW:  cmd_o.ld_finish = 1'b1;
      S_PUTS: cmd_o.puts_step = 1'b1;
      S_DONE: cmd_o.result = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: if (start_i) begin
          state_q <= S_DISP;
          busy_q <= 1'b1;
        end
        S_DISP: begin
          if (stat_i.cmd == CMD_STEP && !stat_i.stopped)
            state_q <= stat_i.str_active ? S_PUTS : S_FETCH;
          else state_q <= S_DONE;
        end
        S_FETCH: state_q <= S_DEC;
        S_DEC:   state_q <= S_EXEC;
        S_EXEC: begin
          if (is_ind) state_q <= S_IND;
          else if (is_ld || is_st) state_q <= S_DATA;
          else state_q <= S_DONE;
        end
        S_IND:  state_q <= S_DATA;
        S_DATA: state_q <= is_ld ? S_LDW : S_DONE;
        S_LDW:  state_q <= S_DONE;
        S_PUTS: state_q <= S_DONE;
        S_DONE: begin
          state_q <= S_IDLE;
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

  a_busy_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !busy_q) else $error("busy while idle");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("double result strobe");
  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_q) |=> busy_q) else $error("accept without busy");
endmodule

// ----- sv/lc3_instruction_executor.sv -----
// Top level of the LC-3 instruction executor.
// Write, set-PC, the unused command and a step while stopped go from dispatch straight
// to the result state.
// A step goes through fetch, decode and execute, then an indirect and a data access
// on the single memory port and a load writeback as needed; a PUTS character step goes through the PUTS state.
// One transaction at a time; busy is low again in the cycle that done is high.
// The receiver cannot stall, so done lasts one cycle. Reset clears registers,
// PC, flags and stop state; memory is unset.
`timescale 1ns / 1ps
module lc3_instruction_executor import lc3_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic [1:0]  command_i,
  input  logic [15:0] address_i,
  input  logic [15:0] data_i,
  input  logic [7:0]  in_char_i,
  output logic [1:0]  status_o,
  output logic        char_valid_o,
  output logic [7:0]  char_out_o,
  output logic        input_used_o,
  output logic [15:0] pc_now_o
);

  dp_cmd_t  dcmd;
  dp_stat_t dstat;

  lc3_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .done_o(done),
    .cmd_o(dcmd), .stat_i(dstat)
  );

  lc3_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(dcmd), .stat_o(dstat),
    .command_i, .address_i, .data_i, .in_char_i,
    .status_o, .char_valid_o, .char_out_o, .input_used_o, .pc_now_o
  );

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the LC-3 instruction executor with a built-in machine predictor.
`timescale 1ns / 1ps
module tb_top;
  import lc3_pkg::*;

  localparam logic [3:0] OpRti = 4'h8;
  localparam logic [3:0] OpRsv = 4'hD;
  localparam logic [2:0] FlagN = 3'd4;
  localparam logic [2:0] FlagZ = 3'd2;
  localparam logic [2:0] FlagP = 3'd1;
  localparam int unsigned NumItems = 1700;

  typedef struct {
    cmd_e        cmd;
    logic [15:0] addr;
    logic [15:0] data;
    logic [7:0]  ch;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        cvalid;
    logic [7:0]  cout;
    logic        used;
    logic [15:0] pc;
  } outcome_t;

  typedef struct {
    logic [15:0] r [8];
    logic [2:0]  nzp;
    logic [15:0] pc;
    stop_e       stop;
    logic [15:0] cursor;
    logic        str_on;
  } machine_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        done;
  logic [1:0]  command_i = 2'd0;
  logic [15:0] address_i = 16'd0;
  logic [15:0] data_i = 16'd0;
  logic [7:0]  in_char_i = 8'd0;
  logic [1:0]  status_o;
  logic        char_valid_o;
  logic [7:0]  char_out_o;
  logic        input_used_o;
  logic [15:0] pc_now_o;

  cmd_item_t   pending_cmds [$];
  outcome_t    expected_outcomes [$];
  machine_t    plan_cpu;
  machine_t    model_cpu;
  logic [15:0] plan_mem [int];
  logic [15:0] model_mem [int];
  int unsigned accepted = 0;
  int unsigned idle_pct = 0;
  bit          taken = 1'b0;
  bit          drain = 1'b0;
  bit          failed = 1'b0;

  lc3_instruction_executor uut (
    .clk_i, .rst_ni, .start, .busy, .done, .command_i, .address_i, .data_i,
    .in_char_i, .status_o, .char_valid_o, .char_out_o, .input_used_o, .pc_now_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [15:0] sext(logic [15:0] w, int bits);
    logic [15:0] v;
    v = w & ((16'd1 << bits) - 16'd1);
    if (v[bits-1]) v = v | (16'hFFFF << bits);
    return v;
  endfunction

  function automatic logic [2:0] flags_of(logic [15:0] v);
    if (v == 16'd0) return FlagZ;
    return v[15] ? FlagN : FlagP;
  endfunction

  function automatic logic [15:0] word_at(ref logic [15:0] m [int], input logic [15:0] a);
    return m.exists(int'(a)) ? m[int'(a)] : 16'd0;
  endfunction

  function automatic void machine_clear(ref machine_t c);
    foreach (c.r[i]) c.r[i] = 16'd0;
    c.nzp = 3'd0;
    c.pc = 16'd0;
    c.stop = ST_RUN;
    c.cursor = 16'd0;
    c.str_on = 1'b0;
  endfunction

  // Applies one command to a machine state and returns the result it reports.
  task automatic lc3_apply(ref machine_t c, ref logic [15:0] m [int], input cmd_item_t it,
                           output outcome_t res);
    logic [15:0] ins, v, tgt, w;
    logic [3:0]  op;
    logic [2:0]  dr, sr1, sr2;
    res = '0;
    case (it.cmd)
      CMD_WRITE: m[int'(it.addr)] = it.data;
      CMD_SETPC: begin
        c.pc = it.data;
        c.stop = ST_RUN;
        c.str_on = 1'b0;
      end
      CMD_STEP: if (c.stop == ST_RUN) begin
        if (c.str_on) begin
          w = word_at(m, c.cursor);
          if (w == 16'd0) begin
            c.str_on = 1'b0;
          end else begin
            res.cvalid = 1'b1;
            res.cout = w[7:0];
            c.cursor = c.cursor + 16'd1;
          end
        end else begin
          ins = word_at(m, c.pc);
          op = ins[15:12];
          dr = ins[11:9];
          sr1 = ins[8:6];
          sr2 = ins[2:0];
          c.pc = c.pc + 16'd1;
          case (op)
            OpBr: if ((dr & c.nzp) != 3'd0) c.pc = c.pc + sext(ins, 9);
            OpAdd, OpAnd: begin
              v = ins[5] ? sext(ins, 5) : c.r[sr2];
              v = (op == OpAdd) ? c.r[sr1] + v : c.r[sr1] & v;
              c.r[dr] = v;
              c.nzp = flags_of(v);
            end
            OpLd, OpLdr, OpLdi, OpLea, OpNot: begin
              if (op == OpLd) v = word_at(m, c.pc + sext(ins, 9));
              else if (op == OpLdr) v = word_at(m, c.r[sr1] + sext(ins, 6));
              else if (op == OpLdi) v = word_at(m, word_at(m, c.pc + sext(ins, 9)));
              else if (op == OpLea) v = c.pc + sext(ins, 9);
              else v = ~c.r[sr1];
              c.r[dr] = v;
              c.nzp = flags_of(v);
            end
            OpSt: begin
              tgt = c.pc + sext(ins, 9);
              m[int'(tgt)] = c.r[dr];
            end
            OpStr: begin
              tgt = c.r[sr1] + sext(ins, 6);
              m[int'(tgt)] = c.r[dr];
            end
            OpSti: m[int'(word_at(m, c.pc + sext(ins, 9)))] = c.r[dr];
            OpJsr: begin
              tgt = ins[11] ? c.pc + sext(ins, 11) : c.r[sr1];
              c.r[7] = c.pc;
              c.pc = tgt;
            end
            OpJmp: c.pc = c.r[sr1];
            OpTrap: begin
              case (ins[7:0])
                TrapGetc: begin
                  c.r[0] = {8'd0, it.ch};
                  res.used = 1'b1;
                end
                TrapOut: begin
                  res.cvalid = 1'b1;
                  res.cout = c.r[0][7:0];
                end
                TrapPuts: begin
                  c.cursor = c.r[0];
                  c.str_on = 1'b1;
                end
                TrapIn: begin
                  c.r[0] = {8'd0, it.ch};
                  res.used = 1'b1;
                  res.cvalid = 1'b1;
                  res.cout = it.ch;
                end
                TrapHalt: c.stop = ST_HALT;
                default: ;
              endcase
            end
            default: c.stop = ST_ERR;
          endcase
        end
      end
      default: ;
    endcase
    res.status = c.stop;
    res.pc = c.pc;
  endtask

  // Finds a word that the next step would read before it was ever written.
  function automatic int unwritten_read(ref machine_t c, ref logic [15:0] m [int],
                                        output bit is_fetch);
    logic [15:0] ins, p, nxt;
    is_fetch = 1'b0;
    if (c.stop != ST_RUN) return -1;
    if (c.str_on) return m.exists(int'(c.cursor)) ? -1 : int'(c.cursor);
    if (!m.exists(int'(c.pc))) begin
      is_fetch = 1'b1;
      return int'(c.pc);
    end
    ins = m[int'(c.pc)];
    nxt = c.pc + 16'd1;
    case (ins[15:12])
      OpLd: p = nxt + sext(ins, 9);
      OpLdr: p = c.r[ins[8:6]] + sext(ins, 6);
      OpLdi, OpSti: begin
        p = nxt + sext(ins, 9);
        if (m.exists(int'(p)) && ins[15:12] == OpLdi) p = m[int'(p)];
        else if (m.exists(int'(p))) return -1;
      end
      default: return -1;
    endcase
    return m.exists(int'(p)) ? -1 : int'(p);
  endfunction

  function automatic logic [15:0] random_instruction();
    logic [15:0] ins;
    logic [7:0]  vec [6];
    ins = 16'($urandom);
    if ($urandom_range(19) != 0 && (ins[15:12] == OpRti || ins[15:12] == OpRsv))
      ins[15:12] = OpAdd;
    if (ins[15:12] == OpTrap || $urandom_range(9) == 0) begin
      vec = '{TrapGetc, TrapOut, TrapPuts, TrapIn, TrapHalt, 8'($urandom)};
      ins = {OpTrap, 4'($urandom), vec[$urandom_range(5)]};
      if (ins[7:0] == TrapHalt && $urandom_range(2) != 0) ins[7:0] = TrapOut;
    end
    return ins;
  endfunction

  task automatic plan(cmd_e cmd, logic [15:0] addr, logic [15:0] data, logic [7:0] ch);
    cmd_item_t it;
    outcome_t  dummy;
    it = '{cmd, addr, data, ch};
    pending_cmds.push_back(it);
    lc3_apply(plan_cpu, plan_mem, it, dummy);
  endtask

  // Issues a step after writing every word it would otherwise read unset.
  task automatic plan_step(logic [7:0] ch);
    int a;
    bit is_fetch;
    a = unwritten_read(plan_cpu, plan_mem, is_fetch);
    while (a >= 0) begin
      plan(CMD_WRITE, 16'(a), is_fetch ? random_instruction() :
           ($urandom_range(3) == 0 ? 16'd0 : 16'($urandom)), 8'($urandom));
      a = unwritten_read(plan_cpu, plan_mem, is_fetch);
    end
    plan(CMD_STEP, 16'($urandom), 16'($urandom), ch);
  endtask

  task automatic build_stimulus();
    logic [15:0] prog [11];
    int unsigned r;
    prog = '{16'h1230, 16'h546F, 16'h96BF, 16'hE004, {8'hF0, TrapPuts}, {8'hF0, TrapOut},
             {8'hF0, TrapIn}, {8'hF0, TrapHalt}, 16'h004F, 16'h004B, 16'h0000};
    plan(CMD_WRITE, 16'hFFFF, 16'hFFFF, 8'hFF);
    plan(CMD_NOP, 16'hFFFF, 16'hFFFF, 8'hFF);
    foreach (prog[i]) plan(CMD_WRITE, 16'h3000 + 16'(i), prog[i], 8'h00);
    plan(CMD_SETPC, 16'h0000, 16'h3000, 8'h00);
    repeat (12) plan_step(8'hFF);
    while (pending_cmds.size() < NumItems) begin
      r = $urandom_range(99);
      if (plan_cpu.stop != ST_RUN && $urandom_range(1) == 0)
        plan(CMD_SETPC, 16'($urandom), $urandom_range(1) ? 16'h3000 : 16'($urandom),
             8'($urandom));
      else if (r < 6)
        plan(CMD_WRITE, 16'($urandom), 16'($urandom), 8'($urandom));
      else if (r < 9)
        plan(CMD_SETPC, 16'($urandom), 16'($urandom), 8'($urandom));
      else if (r < 10)
        plan(CMD_NOP, 16'($urandom), 16'($urandom), 8'($urandom));
      else
        plan_step(8'($urandom));
    end
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && (!start || taken)) begin
      taken = 1'b0;
      if (drain && expected_outcomes.size() == 0) drain = 1'b0;
      if (pending_cmds.size() > 0 && !drain && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        command_i <= pending_cmds[0].cmd;
        address_i <= pending_cmds[0].addr;
        data_i <= pending_cmds[0].data;
        in_char_i <= pending_cmds[0].ch;
        void'(pending_cmds.pop_front());
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    outcome_t got, want;
    cmd_item_t it;
    int unsigned pct [4];
    pct = '{0, 72, 0, 24};
    if (rst_ni && done) begin
      got = '{status_o, char_valid_o, char_out_o, input_used_o, pc_now_o};
      if (expected_outcomes.size() == 0) begin
        $display("%0t: result with no transaction pending: %p", $realtime, got);
        failed = 1'b1;
      end else begin
        want = expected_outcomes.pop_front();
        if (got !== want) begin
          $display("%0t: expected %p, actual %p", $realtime, want, got);
          failed = 1'b1;
        end
      end
    end
    if (rst_ni && start && !busy) begin
      it = '{cmd_e'(command_i), address_i, data_i, in_char_i};
      lc3_apply(model_cpu, model_mem, it, want);
      expected_outcomes.push_back(want);
      accepted++;
      taken = 1'b1;
      idle_pct = pct[(accepted / 150) % 4];
      if (accepted % 250 == 0) drain = 1'b1;
    end
  end

  initial begin
    machine_clear(plan_cpu);
    machine_clear(model_cpu);
    build_stimulus();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    while (pending_cmds.size() != 0 || start || expected_outcomes.size() != 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (!failed) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
